>>> sv/assert_macros.svh
// assertion helpers for the rtl files, included by the top unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every clock edge outside reset
`define PVEG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pveg: assertion failed");
// checked on every clock edge, reset included
`define PVEG_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error("pveg: reset assertion failed");
`else
`define PVEG_ASSERT(label, prop)
`define PVEG_ASSERT_RST(label, prop)
`endif

`endif

>>> sv/pveg_pkg.sv
package pveg_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_KEY_ON   = 2'd0;
    localparam logic [1:0] OP_KEY_OFF  = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;  // undefined, leaves the state unchanged and reports it

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 32;
    localparam int unsigned ITEM_W    = 43;
    localparam int unsigned GAIN_W    = 13;
    localparam int unsigned LVL_OUT_W = 10;
    localparam int unsigned CODE_W    = 4;

    localparam logic [CODE_W-1:0] CODE_MAX = 4'hf;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY1  = 2'd1,
        PH_DECAY2  = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   playing;
    } t_env_ctl;

    // input transaction fields, first field in the highest bits
    typedef struct packed {
        logic [3:0] key_scale;
        logic [3:0] release_req;
        logic [3:0] sustain_code;
        logic [3:0] decay_second;
        logic [3:0] decay_first;
        logic [3:0] attack;
        logic [9:0] pitch;
        logic [3:0] octave;
        logic [4:0] voice;
    } t_item;

    typedef logic [63:0][63:0]         t_step_rom;
    typedef logic [1023:0][GAIN_W-1:0] t_gain_rom;

    localparam logic [63:0] RATIO_E5     = 64'd1432833;
    localparam logic [63:0] LOG_STEP_Q32 = 64'd66879246;
    localparam logic [63:0] LN2_Q32      = 64'hB17217F8;

    // base envelope times, hundredths of a millisecond
    localparam logic [31:0] TIME_CMS [64] = '{
        0, 0, 0, 0,
        622295, 497837, 414866, 355601, 311147, 248921, 207433, 177800,
        155574, 124463, 103719, 88902, 77787, 62231, 51859, 44454,
        38893, 31116, 25932, 22227, 19447, 15560, 12966, 11116,
        9723, 7782, 6485, 5560, 4862, 3891, 3243, 2780,
        2431, 1946, 1624, 1392, 1215, 975, 812, 698,
        608, 490, 408, 349, 304, 249, 213, 190,
        172, 141, 118, 104, 91, 73, 59, 50,
        45, 45, 45, 45
    };

    // floor of num / den, shift and subtract
    function automatic logic [63:0] div_floor(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // step per tick for each rate index, elaborated once
    function automatic t_step_rom step_rom_build(input int unsigned eg_shift,
                                                 input logic is_decay);
        t_step_rom   rom;
        logic [63:0] full;
        logic [63:0] t;
        full = 64'd1 << (10 + eg_shift);
        for (int i = 0; i < 64; i++) begin
            t = 64'(TIME_CMS[i]);
            if (i < 4 || t == 64'd0) begin
                rom[i] = 64'd0;
            end else if (is_decay) begin
                rom[i] = div_floor(full * 64'd100000000, t * 64'd441 * RATIO_E5);
            end else begin
                rom[i] = div_floor(full * 64'd1000, t * 64'd441);
            end
        end
        if (!is_decay) begin
            rom[63] = 64'd1 << (10 + eg_shift);
        end
        return rom;
    endfunction

    // 2^-f for a q32 fraction, taylor series of e^-y
    function automatic logic [63:0] exp2_neg_frac(input logic [63:0] f);
        logic [63:0] y;
        logic [63:0] sum;
        logic [63:0] term;
        y    = (f * LN2_Q32) >> 32;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= 20; n++) begin
            term = div_floor((term * y) >> 32, 64'(n));
            if ((n & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_gain_rom gain_rom_build(input int unsigned gain_shift);
        t_gain_rom   rom;
        logic [63:0] a;
        logic [63:0] whole;
        logic [63:0] m;
        for (int i = 0; i < 1024; i++) begin
            a      = 64'(1024 - i) * LOG_STEP_Q32;
            whole  = a >> 32;
            m      = exp2_neg_frac(a & 64'h0000_0000_ffff_ffff);
            rom[i] = GAIN_W'((m << gain_shift) >> (64'd32 + whole));
        end
        return rom;
    endfunction

endpackage

>>> sv/pveg_ram.sv
module pveg_ram
    import pveg_pkg::*;
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pveg_keyon.sv
module pveg_keyon
    import pveg_pkg::*;
#(
    parameter int unsigned EG_SHIFT = 16,
    localparam int unsigned SW = 11 + EG_SHIFT
) (
    input  t_item             i_item,
    output logic [SW-1:0]     o_attack_step,
    output logic [SW-1:0]     o_decay_first_step,
    output logic [SW-1:0]     o_decay_second_step,
    output logic [SW-1:0]     o_release_step,
    output logic [CODE_W-1:0] o_threshold
);

    localparam t_step_rom ATTACK_ROM = step_rom_build(EG_SHIFT, 1'b0);
    localparam t_step_rom DECAY_ROM  = step_rom_build(EG_SHIFT, 1'b1);

    logic signed [5:0] w_oct_ks;
    logic signed [7:0] w_rate;

    // code 0 is no step, code 15 the fastest entry, else 4*code + rate clamped
    function automatic logic [5:0] rom_index(input logic [3:0] code,
                                             input logic signed [7:0] rate);
        logic signed [7:0] idx;
        idx = $signed({2'b00, code, 2'b00}) + rate;
        if (code == 4'd0) begin
            rom_index = 6'd0;
        end else if (code == CODE_MAX) begin
            rom_index = 6'd63;
        end else if (idx < 8'sd0) begin
            rom_index = 6'd0;
        end else if (idx > 8'sd63) begin
            rom_index = 6'd63;
        end else begin
            rom_index = idx[5:0];
        end
    endfunction

    always_comb begin
        w_oct_ks = $signed({{2{i_item.octave[3]}}, i_item.octave})
                 + $signed({2'b00, i_item.key_scale});
        if (i_item.key_scale == CODE_MAX) begin
            w_rate = 8'sd0;
        end else begin
            w_rate = $signed({w_oct_ks[5], w_oct_ks, 1'b0})
                   + $signed({7'd0, i_item.pitch[9]});
        end
    end

    assign o_attack_step       = ATTACK_ROM[rom_index(i_item.attack, w_rate)][SW-1:0];
    assign o_decay_first_step  = DECAY_ROM[rom_index(i_item.decay_first, w_rate)][SW-1:0];
    assign o_decay_second_step = DECAY_ROM[rom_index(i_item.decay_second, w_rate)][SW-1:0];
    assign o_release_step      = DECAY_ROM[rom_index(i_item.release_req, w_rate)][SW-1:0];
    assign o_threshold         = CODE_MAX - i_item.sustain_code;

endmodule

>>> sv/pveg_update.sv
module pveg_update
    import pveg_pkg::*;
#(
    parameter int unsigned EG_SHIFT = 16,
    localparam int unsigned LW = 10 + EG_SHIFT,
    localparam int unsigned SW = LW + 1
) (
    input  logic [1:0]        i_op,
    input  logic [CODE_W-1:0] i_release_req,
    input  t_env_ctl          i_ctl,
    input  logic [LW-1:0]     i_level,
    input  logic [SW-1:0]     i_attack_step,
    input  logic [SW-1:0]     i_decay_first_step,
    input  logic [SW-1:0]     i_decay_second_step,
    input  logic [SW-1:0]     i_release_step,
    input  logic [CODE_W-1:0] i_threshold,
    output t_env_ctl          o_ctl,
    output logic [LW-1:0]     o_level
);

    localparam logic [SW-1:0] LEVEL_FULL   = {1'b0, 10'h3ff, {EG_SHIFT{1'b0}}};
    localparam logic [SW-1:0] STEP_INSTANT = {1'b1, {LW{1'b0}}};

    logic [SW-1:0] w_lv;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_step;
    logic [LW-1:0] w_dec;
    logic          w_floor;

    // one shared subtract for both decays and release
    always_comb begin
        w_lv  = {1'b0, i_level};
        w_sum = w_lv + i_attack_step;
        unique case (i_ctl.phase)
            PH_DECAY1: w_step = i_decay_first_step;
            PH_DECAY2: w_step = i_decay_second_step;
            default:   w_step = i_release_step;
        endcase
        w_floor = (w_step >= w_lv);
        w_dec   = w_floor ? '0 : LW'(w_lv - w_step);
    end

    always_comb begin
        o_ctl   = i_ctl;
        o_level = i_level;
        unique case (i_op)
            OP_KEY_ON: begin
                o_ctl.phase   = PH_ATTACK;
                o_ctl.playing = 1'b1;
                o_level       = '0;
            end
            OP_KEY_OFF: begin
                if (i_ctl.playing) begin
                    if (i_release_req != CODE_MAX) begin
                        o_ctl.phase = PH_RELEASE;
                    end else begin
                        o_ctl.playing = 1'b0;
                    end
                end
            end
            OP_TICK: begin
                if (i_ctl.playing) begin
                    unique case (i_ctl.phase)
                        PH_ATTACK: begin
                            if (w_sum >= LEVEL_FULL) begin
                                o_ctl.phase = (i_decay_first_step >= STEP_INSTANT)
                                            ? PH_DECAY2 : PH_DECAY1;
                                o_level = LEVEL_FULL[LW-1:0];
                            end else begin
                                o_level = w_sum[LW-1:0];
                            end
                        end
                        PH_DECAY1: begin
                            o_level = w_dec;
                            if (w_dec[LW-1 -: 4] <= i_threshold) begin
                                o_ctl.phase = PH_DECAY2;
                            end
                        end
                        PH_DECAY2: begin
                            o_level = w_dec;
                        end
                        default: begin
                            o_level = w_dec;
                            if (w_floor) begin
                                o_ctl.playing = 1'b0;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

endmodule

>>> sv/pcm_voice_envelope_generator_unit.sv
// channel    | dir | tdata fields, lowest bit up                     | tuser
// s_axis     | in  | voice, octave, pitch, attack, decay_first,       | operation
//            |     | decay_second, sustain_code, release_req,         |
//            |     | key_scale (43 bits, zero filled to 48)           |
// m_axis     | out | voice_out, gain, level, phase, playing           | -
//            |     | (31 bits, zero filled to 32)                     |
//
// a new transaction is taken in the idle state or while the previous result is
// loaded, as the voice memories are read through a register: accept addresses
// them, the next cycle updates and writes back, the one after loads the result
// through the registered gain lookup, which also raises output valid
// reset (synchronous, active low) clears the voice valid bits, so every voice
// reads as silent with zero state; no clearing pass is needed
// a stalled output holds the block in the lookup state until the result is taken
module pcm_voice_envelope_generator_unit
    import pveg_pkg::*;
#(
    parameter int unsigned VOICES     = 28,
    parameter int unsigned EG_SHIFT   = 16,
    parameter int unsigned GAIN_SHIFT = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // voice, octave, pitch, attack, decay_first, decay_second, sustain_code,
    // release_req, key_scale
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // operation
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // voice_out, gain, level, phase, playing
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    `include "assert_macros.svh"

    localparam int unsigned AW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned LW    = 10 + EG_SHIFT;       // level with fraction bits
    localparam int unsigned SW    = LW + 1;              // step, reaches 0x400 << shift
    localparam int unsigned ENV_W = 3 + LW;              // phase, playing, level
    localparam int unsigned PAR_W = 4 * SW + CODE_W;     // four steps and threshold

    localparam t_gain_rom GAIN_ROM = gain_rom_build(GAIN_SHIFT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_LOOK = 3'b100
    } t_state;

    t_state r_state, n_state;

    t_item w_in_item;
    t_item r_item;
    logic [1:0] r_op;

    logic w_s_accept;
    logic w_out_free;
    logic w_out_load;

    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_addr;
    logic          w_in_range;
    logic          w_hit;
    logic [VOICES-1:0] r_valid;

    // voice memories
    logic [ENV_W-1:0] w_env_rdata, w_env_wdata;
    logic [PAR_W-1:0] w_par_rdata, w_par_wdata;
    logic             w_env_we, w_par_we;

    // state as read, zero for voices never keyed on since reset
    t_env_ctl         w_cur_ctl;
    logic [LW-1:0]    w_cur_level;
    logic [SW-1:0]    w_cur_atk, w_cur_d1, w_cur_d2, w_cur_rel;
    logic [CODE_W-1:0] w_cur_thr;

    // fresh steps from the key-on transaction
    logic [SW-1:0]     w_new_atk, w_new_d1, w_new_d2, w_new_rel;
    logic [CODE_W-1:0] w_new_thr;

    t_env_ctl      w_upd_ctl;
    logic [LW-1:0] w_upd_level;

    // result staging between update and gain lookup
    logic [4:0]           r_res_voice;
    logic [LVL_OUT_W-1:0] r_res_level;
    t_phase               r_res_phase;
    logic                 r_res_playing;
    logic                 r_res_in_range;

    logic                 r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic [GAIN_W-1:0]    w_gain;

    assign w_in_item  = t_item'(i_s_axis_tdata[ITEM_W-1:0]);
    assign w_out_free = !r_m_tvalid || i_m_axis_tready;
    assign w_out_load = (r_state == ST_LOOK) && w_out_free;

    // next transaction may enter while the previous result is being loaded;
    // its read lands after the write back of the previous one
    assign o_s_axis_tready = (r_state == ST_IDLE) || w_out_load;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    assign w_raddr    = AW'(w_in_item.voice);
    assign w_addr     = AW'(r_item.voice);
    assign w_in_range = (32'(r_item.voice) < VOICES);
    assign w_hit      = w_in_range && r_valid[w_addr];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_s_accept) n_state = ST_CALC;
            ST_CALC: n_state = ST_LOOK;
            ST_LOOK: begin
                if (w_out_free) begin
                    n_state = w_s_accept ? ST_CALC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_item <= w_in_item;
            r_op   <= i_s_axis_tuser;
        end
    end

    pveg_ram #(
        .WIDTH (ENV_W),
        .DEPTH (VOICES)
    ) u_env_ram (
        .i_clk   (i_clk),
        .i_we    (w_env_we),
        .i_waddr (w_addr),
        .i_wdata (w_env_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_env_rdata)
    );

    pveg_ram #(
        .WIDTH (PAR_W),
        .DEPTH (VOICES)
    ) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (w_addr),
        .i_wdata (w_par_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_par_rdata)
    );

    always_comb begin
        if (w_hit) begin
            w_cur_ctl.phase   = t_phase'(w_env_rdata[LW+2:LW+1]);
            w_cur_ctl.playing = w_env_rdata[LW];
            w_cur_level       = w_env_rdata[LW-1:0];
            w_cur_atk         = w_par_rdata[SW-1:0];
            w_cur_d1          = w_par_rdata[2*SW-1:SW];
            w_cur_d2          = w_par_rdata[3*SW-1:2*SW];
            w_cur_rel         = w_par_rdata[4*SW-1:3*SW];
            w_cur_thr         = w_par_rdata[PAR_W-1:4*SW];
        end else begin
            w_cur_ctl.phase   = PH_ATTACK;
            w_cur_ctl.playing = 1'b0;
            w_cur_level       = '0;
            w_cur_atk         = '0;
            w_cur_d1          = '0;
            w_cur_d2          = '0;
            w_cur_rel         = '0;
            w_cur_thr         = '0;
        end
    end

    pveg_keyon #(
        .EG_SHIFT (EG_SHIFT)
    ) u_keyon (
        .i_item              (r_item),
        .o_attack_step       (w_new_atk),
        .o_decay_first_step  (w_new_d1),
        .o_decay_second_step (w_new_d2),
        .o_release_step      (w_new_rel),
        .o_threshold         (w_new_thr)
    );

    // a tick uses the steps stored at the last key-on
    pveg_update #(
        .EG_SHIFT (EG_SHIFT)
    ) u_update (
        .i_op                (r_op),
        .i_release_req       (r_item.release_req),
        .i_ctl               (w_cur_ctl),
        .i_level             (w_cur_level),
        .i_attack_step       (w_cur_atk),
        .i_decay_first_step  (w_cur_d1),
        .i_decay_second_step (w_cur_d2),
        .i_release_step      (w_cur_rel),
        .i_threshold         (w_cur_thr),
        .o_ctl               (w_upd_ctl),
        .o_level             (w_upd_level)
    );

    // write back in the update cycle; out of range voices leave memory alone
    assign w_env_we    = (r_state == ST_CALC) && w_in_range;
    assign w_par_we    = w_env_we && (r_op == OP_KEY_ON);
    assign w_env_wdata = {w_upd_ctl.phase, w_upd_ctl.playing, w_upd_level};
    assign w_par_wdata = {w_new_thr, w_new_rel, w_new_d2, w_new_d1, w_new_atk};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_par_we) begin
            r_valid[w_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_res_voice    <= r_item.voice;
            r_res_in_range <= w_in_range;
            if (w_in_range) begin
                r_res_level   <= w_upd_level[LW-1 -: LVL_OUT_W];
                r_res_phase   <= w_upd_ctl.phase;
                r_res_playing <= w_upd_ctl.playing;
            end else begin
                r_res_level   <= '0;
                r_res_phase   <= PH_ATTACK;
                r_res_playing <= 1'b0;
            end
        end
    end

    // gain table read straight into the output register
    assign w_gain = r_res_in_range ? GAIN_ROM[r_res_level] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_tdata <= {1'b0, r_res_playing, r_res_phase, r_res_level, w_gain, r_res_voice};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    `PVEG_ASSERT(a_accept_to_calc, w_s_accept |=> (r_state == ST_CALC))
    `PVEG_ASSERT(a_calc_to_look, (r_state == ST_CALC) |=> (r_state == ST_LOOK))
    `PVEG_ASSERT(a_write_in_calc, (w_env_we || w_par_we) |-> (r_state == ST_CALC))
    `PVEG_ASSERT_RST(a_reset_idle, !i_rst_n |=> ((r_state == ST_IDLE) && !r_m_tvalid))

endmodule
